// ===== design/tip_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tip_pkg
// shared constants, types and character helpers of the text to integer parser
// ---------------------------------------------------------------------------
package tip_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_LEN_DEF    = 4095;

    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int DIGIT_W      = 7;
    localparam int OFFSET_W     = 12;
    localparam int VALUE_PORT_W = 64;
    localparam int M_TDATA_W    = 80;
    localparam int M_TUSER_W    = 2;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 8'd1;

    localparam logic [BASE_W-1:0] BASE_AUTO     = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT      = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC      = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX      = 6'd16;
    localparam logic [BASE_W-1:0] BASE_RESET    = BASE_DEC;

    localparam logic [DIGIT_W-1:0] NO_DIGIT     = 7'd64;
    localparam logic [DIGIT_W-1:0] LETTER_BIAS  = 7'd10;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] digit;
    } t_mac_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_mac_stat;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            d = DIGIT_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = DIGIT_W'(c - CH_LA) + LETTER_BIAS;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = DIGIT_W'(c - CH_UA) + LETTER_BIAS;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage
`default_nettype wire

// ===== design/tip_mac.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tip_mac
// shift-add multiply-accumulate unit: acc * base + digit, one base bit a cycle
// ---------------------------------------------------------------------------
module tip_mac #(
    parameter int VALUE_BITS = tip_pkg::VALUE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire tip_pkg::t_mac_req    i_req,
    input  wire  [VALUE_BITS-1:0]     i_acc,
    output tip_pkg::t_mac_stat        o_stat,
    output logic [VALUE_BITS-1:0]     o_acc
);
    import tip_pkg::*;

    localparam int PROD_W = VALUE_BITS + BASE_W;
    localparam int CNT_W  = $clog2(BASE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BASE_W - 1);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_mcand;
    logic [BASE_W-1:0] r_mplier;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_prod   <= PROD_W'(i_req.digit);
                r_mcand  <= PROD_W'(i_acc);
                r_mplier <= i_req.base;
                r_cnt    <= '0;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc       = r_prod[VALUE_BITS-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = |r_prod[PROD_W-1:VALUE_BITS];

endmodule
`default_nettype wire

// ===== design/tip_fmt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tip_fmt
// result former: sign, saturation and clamping of the accumulated magnitude
// ---------------------------------------------------------------------------
module tip_fmt #(
    parameter int VALUE_BITS = tip_pkg::VALUE_BITS_DEF
) (
    input  wire  [VALUE_BITS-1:0] i_acc,
    input  wire                   i_ovf,
    input  wire                   i_neg,
    input  wire                   i_signed_mode,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_range_error
);
    import tip_pkg::*;

    localparam logic [VALUE_BITS-1:0] SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [VALUE_BITS-1:0] neg_acc;
    logic                  above_smin;

    assign neg_acc    = '0 - i_acc;
    assign above_smin = i_acc[VALUE_BITS-1] && (|i_acc[VALUE_BITS-2:0]);

    always_comb begin
        o_value       = i_acc;
        o_range_error = 1'b0;
        if (i_signed_mode) begin
            if (i_ovf) begin
                o_range_error = 1'b1;
                o_value       = i_neg ? SMIN : SMAX;
            end else if (i_neg) begin
                if (above_smin) begin
                    o_range_error = 1'b1;
                    o_value       = SMIN;
                end else begin
                    o_value = neg_acc;
                end
            end else if (i_acc[VALUE_BITS-1]) begin
                o_range_error = 1'b1;
                o_value       = SMAX;
            end
        end else if (i_ovf) begin
            o_range_error = 1'b1;
            o_value       = '1;
        end else if (i_neg) begin
            o_value = neg_acc;
        end
    end

endmodule
`default_nettype wire

// ===== design/text_to_integer_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// text_to_integer_parser
// streaming strtoul/strtol: one string byte per transfer in, one integer out
// ---------------------------------------------------------------------------
// usage
//   slave stream: tdata carries one byte, tuser marks the first byte of a string
//   master stream: tdata carries value and end offset, tuser the two flags
//   cfg channel: index 0 number_base (0 = auto), index 1 signed_mode; always ready
// byte handling
//   white space, sign, prefix and terminating bytes need no shift-add steps
//   a digit takes the transfer, 6 steps of the shift-add unit,
//   one step per bit of the base, and a write-back step, during which
//   tready stays low
// latency
//   the result is in the output register the cycle after the byte that ends
//   the number; a new byte may be taken in that same cycle
// stall
//   while a result waits, tready follows the master tready so no result is lost
// reset
//   synchronous active low; base returns to 10, unsigned mode, no string open,
//   bytes before the first string start produce nothing
// ---------------------------------------------------------------------------
module text_to_integer_parser #(
    parameter int MAX_LEN    = tip_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = tip_pkg::VALUE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [tip_pkg::CHAR_W-1:0]         i_s_tdata,   // [7:0] character
    input  wire                                i_s_tuser,   // [0] string_start
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [63:0] value, [75:64] end_offset, [79:76] zero
    output logic [tip_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [0] range_error, [1] digits_found
    output logic [tip_pkg::M_TUSER_W-1:0]      o_m_tuser,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [tip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tip_pkg::BASE_W-1:0]         i_cfg_data
);
    import tip_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
    localparam int PAD_W = M_TDATA_W - VALUE_PORT_W - OFFSET_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SPACE, ST_FIRST, ST_ZERO, ST_XSEEN, ST_DIGITS, ST_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [BASE_W-1:0]     r_number_base;
    logic                  r_signed_mode;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_neg, n_neg;
    logic [BASE_W-1:0]     r_base, n_base;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_any, n_any;
    logic [POS_W-1:0]      r_xoff, n_xoff;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [OFFSET_W-1:0]   r_end;
    logic                  r_rerr;
    logic                  r_dig;

    t_mac_req              mac_req;
    t_mac_stat             mac_stat;
    logic [VALUE_BITS-1:0] mac_acc;

    logic                  s_xfer;
    logic                  emit;
    logic [POS_W-1:0]      emit_end;
    logic [VALUE_BITS-1:0] acc_cur;
    logic                  ovf_cur;
    logic [DIGIT_W-1:0]    dval;
    logic [VALUE_BITS-1:0] fmt_value;
    logic                  fmt_rerr;
    logic                  fall;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !mac_stat.busy && !mac_stat.done && (!r_out_valid || i_m_tready);
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign acc_cur     = mac_stat.done ? mac_acc : r_acc;
    assign ovf_cur     = r_ovf || (mac_stat.done && mac_stat.ovf);
    assign dval        = digit_of(i_s_tdata);

    always_comb begin
        n_state  = r_state;
        n_acc    = acc_cur;
        n_ovf    = ovf_cur;
        n_neg    = r_neg;
        n_base   = r_base;
        n_pos    = r_pos;
        n_any    = r_any;
        n_xoff   = r_xoff;
        emit     = 1'b0;
        emit_end = '0;
        fall     = 1'b0;
        mac_req  = '{start: 1'b0, base: '0, digit: '0};
        if (s_xfer) begin
            if (i_s_tuser) begin
                n_state = ST_SPACE;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_neg   = 1'b0;
                n_base  = r_number_base;
                n_pos   = '0;
                n_any   = 1'b0;
                n_xoff  = '0;
            end
            fall = (n_state != ST_IDLE) && (n_state != ST_DONE);
            if (fall && n_state == ST_SPACE) begin
                if (is_space(i_s_tdata)) begin
                    fall = 1'b0;
                end else begin
                    n_state = ST_FIRST;
                    if (i_s_tdata == CH_PLUS || i_s_tdata == CH_MINUS) begin
                        n_neg = (i_s_tdata == CH_MINUS);
                        fall  = 1'b0;
                    end
                end
                if (!fall) begin
                    n_pos = (n_pos < POS_MAX) ? n_pos + 1'b1 : n_pos;
                end
            end
            if (fall && n_state == ST_FIRST) begin
                if ((n_base == BASE_AUTO || n_base == BASE_HEX) && i_s_tdata == CH_0) begin
                    n_acc   = '0;
                    n_any   = 1'b1;
                    n_state = ST_ZERO;
                    n_pos   = (n_pos < POS_MAX) ? n_pos + 1'b1 : n_pos;
                    fall    = 1'b0;
                end else begin
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_DEC;
                    end
                    n_state = ST_DIGITS;
                end
            end
            if (fall && n_state == ST_ZERO) begin
                if (i_s_tdata == CH_LX || i_s_tdata == CH_UX) begin
                    n_xoff  = n_pos;
                    n_state = ST_XSEEN;
                    n_pos   = (n_pos < POS_MAX) ? n_pos + 1'b1 : n_pos;
                    fall    = 1'b0;
                end else begin
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_OCT;
                    end
                    n_state = ST_DIGITS;
                end
            end
            if (fall && n_state == ST_XSEEN) begin
                if (dval >= DIGIT_W'(BASE_HEX)) begin
                    emit     = 1'b1;
                    emit_end = n_xoff;
                    n_state  = ST_DONE;
                    fall     = 1'b0;
                end else begin
                    n_base  = BASE_HEX;
                    n_acc   = '0;
                    n_state = ST_DIGITS;
                end
            end
            if (fall) begin
                if (dval < DIGIT_W'(n_base)) begin
                    mac_req = '{start: 1'b1, base: n_base, digit: dval[BASE_W-1:0]};
                    n_any   = 1'b1;
                    n_pos   = (n_pos < POS_MAX) ? n_pos + 1'b1 : n_pos;
                end else begin
                    emit     = 1'b1;
                    emit_end = n_any ? n_pos : '0;
                    n_state  = ST_DONE;
                end
            end
        end
    end

    tip_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_acc   (n_acc),
        .o_stat  (mac_stat),
        .o_acc   (mac_acc)
    );

    tip_fmt #(
        .VALUE_BITS (VALUE_BITS)
    ) u_fmt (
        .i_acc         (n_acc),
        .i_ovf         (n_ovf),
        .i_neg         (n_neg),
        .i_signed_mode (r_signed_mode),
        .o_value       (fmt_value),
        .o_range_error (fmt_rerr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_number_base <= BASE_RESET;
            r_signed_mode <= 1'b0;
            r_acc         <= '0;
            r_ovf         <= 1'b0;
            r_neg         <= 1'b0;
            r_base        <= '0;
            r_pos         <= '0;
            r_any         <= 1'b0;
            r_xoff        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NUMBER_BASE) begin
                    r_number_base <= i_cfg_data;
                end else if (i_cfg_index == CFG_SIGNED_MODE) begin
                    r_signed_mode <= i_cfg_data[0];
                end
            end
            r_state <= n_state;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_any   <= n_any;
            r_xoff  <= n_xoff;
            if (emit) begin
                r_out_valid <= 1'b1;
                r_value     <= fmt_value;
                r_end       <= OFFSET_W'(emit_end);
                r_rerr      <= fmt_rerr;
                r_dig       <= n_any;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_end, VALUE_PORT_W'(r_value)};
    assign o_m_tuser  = {r_dig, r_rerr};

`ifndef SYNTH
    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_stat.busy |-> !o_s_tready)
        else $error("byte taken while the shift-add unit is busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(mac_stat.busy) |-> mac_stat.done)
        else $error("shift-add unit finished without a done pulse");

    a_no_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata == '0))
        else $error("result without digits carries a value or offset");

    a_rerr_needs_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tuser[1])
        else $error("range error flagged without any digit");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_m_tready))
        else $error("result formed while the output register is held");
`endif

endmodule
`default_nettype wire
